### hdl/xild_pkg.sv
// ----------------------------------------------------------------------------
// xild_pkg: shared types and constants for the x86-64 length decoder
// Holds the request/result payload types, the decode phases and the opcode
// classification functions.
// ----------------------------------------------------------------------------
package xild_pkg;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       restart;
    } req_t;

    typedef struct packed {
        logic       end_of_instruction;
        logic [3:0] instr_length;
        logic       invalid;
        logic [3:0] byte_index;
    } res_t;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_ESC    = 3'd1,
        PH_ESC3   = 3'd2,
        PH_MODRM  = 3'd3,
        PH_SIB    = 3'd4,
        PH_TAIL   = 3'd5
    } phase_t;

    // immediate kinds
    localparam logic [3:0] K0     = 4'd0;
    localparam logic [3:0] K1     = 4'd1;
    localparam logic [3:0] K2     = 4'd2;
    localparam logic [3:0] K3     = 4'd3;
    localparam logic [3:0] K4     = 4'd4;
    localparam logic [3:0] KZ     = 4'd5;
    localparam logic [3:0] KFAR   = 4'd6;
    localparam logic [3:0] KMOFFS = 4'd7;
    localparam logic [3:0] KMOV   = 4'd8;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_0F   = 2'd1;
    localparam logic [1:0] ESC_0F38 = 2'd2;
    localparam logic [1:0] ESC_0F3A = 2'd3;

    localparam logic [7:0] OP_ESC   = 8'h0F;
    localparam logic [7:0] OP_0F38  = 8'h38;
    localparam logic [7:0] OP_0F3A  = 8'h3A;
    localparam logic [7:0] OP_OPSZ  = 8'h66;
    localparam logic [7:0] OP_ADSZ  = 8'h67;
    localparam logic [7:0] OP_GRP3B = 8'hF6;
    localparam logic [7:0] OP_GRP3V = 8'hF7;

    // opcode class: ok, modrm, immediate kind
    typedef struct packed {
        logic       ok;
        logic       mrm;
        logic [3:0] kind;
    } cls_t;

    function automatic cls_t mk(input logic m, input logic [3:0] k);
        cls_t c;
        c.ok = 1'b1; c.mrm = m; c.kind = k;
        return c;
    endfunction

    function automatic cls_t class_one(input logic [7:0] op);
        cls_t c;
        c = '0;
        if (op < 8'h40)
        begin
            if (op[2:0] <= 3'd3)      c = mk(1'b1, K0);
            else if (op[2:0] == 3'd4) c = mk(1'b0, K1);
            else if (op[2:0] == 3'd5) c = mk(1'b0, KZ);
            else if (op inside {8'h06, 8'h07, 8'h0E, 8'h16, 8'h17, 8'h1E, 8'h1F})
                c = mk(1'b0, K0);
        end
        else if (op < 8'h60)                          c = mk(1'b0, K0);
        else if (op inside {[8'h70:8'h7F]})           c = mk(1'b0, K1);
        else if (op inside {[8'h84:8'h8F]})           c = mk(1'b1, K0);
        else if (op inside {[8'h90:8'h99], [8'h9C:8'h9F]}) c = mk(1'b0, K0);
        else if (op inside {[8'hA0:8'hA3]})           c = mk(1'b0, KMOFFS);
        else if (op inside {[8'hA4:8'hA7], [8'hAA:8'hAF]}) c = mk(1'b0, K0);
        else if (op inside {[8'hB0:8'hB7]})           c = mk(1'b0, K1);
        else if (op inside {[8'hB8:8'hBF]})           c = mk(1'b0, KMOV);
        else if (op inside {[8'hD8:8'hDF], [8'hD0:8'hD3]}) c = mk(1'b1, K0);
        else if (op inside {[8'hE0:8'hE7]})           c = mk(1'b0, K1);
        else if (op inside {[8'hEC:8'hEF], [8'hF8:8'hFD]}) c = mk(1'b0, K0);
        else
        begin
            case (op)
                8'h68:                      c = mk(1'b0, KZ);
                8'h69:                      c = mk(1'b1, KZ);
                8'h6A:                      c = mk(1'b0, K1);
                8'h6B:                      c = mk(1'b1, K1);
                8'h80, 8'h82, 8'h83:        c = mk(1'b1, K1);
                8'h81:                      c = mk(1'b1, KZ);
                8'h9A, 8'hEA:               c = mk(1'b0, KFAR);
                8'hA8:                      c = mk(1'b0, K1);
                8'hA9:                      c = mk(1'b0, KZ);
                8'hC0, 8'hC1, 8'hC6:        c = mk(1'b1, K1);
                8'hC2, 8'hCA:               c = mk(1'b0, K2);
                8'hC3, 8'hC9, 8'hCB, 8'hCC, 8'hCE, 8'hCF,
                8'hD7, 8'hF4, 8'hF5:        c = mk(1'b0, K0);
                8'hC4, 8'hC5, 8'hF6, 8'hF7, 8'hFE, 8'hFF:
                                            c = mk(1'b1, K0);
                8'hC7:                      c = mk(1'b1, KZ);
                8'hC8:                      c = mk(1'b0, K3);
                8'hCD, 8'hD4, 8'hD5, 8'hEB: c = mk(1'b0, K1);
                8'hE8, 8'hE9:               c = mk(1'b0, K4);
                default:                    c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic cls_t class_two(input logic [7:0] op);
        cls_t c;
        c = '0;
        if (op inside {[8'h80:8'h8F]})                     c = mk(1'b0, K4);
        else if (op inside {[8'h90:8'h9F], [8'h40:8'h4F]}) c = mk(1'b1, K0);
        else if (op inside {[8'hC8:8'hCF]})                c = mk(1'b0, K0);
        else if (op inside {[8'h20:8'h23]})                c = mk(1'b1, K0);
        else if (op inside {[8'h30:8'h33]})                c = mk(1'b0, K0);
        else
        begin
            case (op)
                8'hA4, 8'hAC, 8'hBA: c = mk(1'b1, K1);
                8'hA3, 8'hAB, 8'hB3, 8'hBB, 8'hA5, 8'hAD, 8'hAF, 8'hB6, 8'hB7,
                8'hBE, 8'hBF, 8'hBC, 8'hBD, 8'hB2, 8'hB4, 8'hB5, 8'h1F, 8'hC0,
                8'hC1, 8'hB0, 8'hB1, 8'hC7:
                                     c = mk(1'b1, K0);
                8'hA0, 8'hA1, 8'hA8, 8'hA9, 8'h05, 8'h07, 8'h34, 8'h35:
                                     c = mk(1'b0, K0);
                default:             c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

### hdl/xild_stream_if.sv
// ----------------------------------------------------------------------------
// xild_stream_if: valid/ready channel
// Carries one payload of type T per request.
// ----------------------------------------------------------------------------
interface xild_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/xild_core.sv
// ----------------------------------------------------------------------------
// xild_core: per-byte length decode state and next-state logic
// Updates the instruction tracking state on each accepted byte and forms
// the result for that byte.
// ----------------------------------------------------------------------------
module xild_core #(
    parameter int MAX_LENGTH = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  xild_pkg::req_t    req,
    output xild_pkg::res_t    res
);

    localparam logic [3:0] LAST_IDX = 4'(MAX_LENGTH - 1);

    xild_pkg::phase_t phase_reg, phase_next;
    logic [3:0] bytes_seen_reg, bytes_seen_next;
    logic       opsz_reg, opsz_next;
    logic       adsz_reg, adsz_next;
    logic       rex_w_reg, rex_w_next;
    logic [1:0] esc_reg, esc_next;
    logic       mrm_reg, mrm_next;
    logic [3:0] imm_reg, imm_next;
    logic [3:0] tail_reg, tail_next;
    logic [1:0] grp3_reg, grp3_next;
    logic [1:0] mod_reg, mod_next;

    // current-instruction view after an optional restart
    xild_pkg::phase_t ph;
    logic [3:0] idx, imm, tail, zsz, disp;
    logic       opsz, adsz, rex_w;
    logic [1:0] esc, grp3, mdm;
    logic       ends, bad, clr;
    xild_pkg::cls_t cls;
    logic       take_op;
    logic [7:0] b;

    function automatic logic [3:0] imm_of(input logic [3:0] k, input logic [3:0] z,
                                          input logic a, input logic w);
        case (k)
            xild_pkg::K1:     return 4'd1;
            xild_pkg::K2:     return 4'd2;
            xild_pkg::K3:     return 4'd3;
            xild_pkg::K4:     return 4'd4;
            xild_pkg::KZ:     return z;
            xild_pkg::KFAR:   return z + 4'd2;
            xild_pkg::KMOFFS: return a ? 4'd4 : 4'd8;
            xild_pkg::KMOV:   return w ? 4'd8 : z;
            default:          return 4'd0;
        endcase
    endfunction

    always_comb
    begin
        clr   = req.restart;
        ph    = clr ? xild_pkg::PH_PREFIX : phase_reg;
        idx   = clr ? 4'd0 : bytes_seen_reg;
        opsz  = clr ? 1'b0 : opsz_reg;
        adsz  = clr ? 1'b0 : adsz_reg;
        rex_w = clr ? 1'b0 : rex_w_reg;
        esc   = clr ? 2'd0 : esc_reg;
        imm   = clr ? 4'd0 : imm_reg;
        tail  = clr ? 4'd0 : tail_reg;
        grp3  = clr ? 2'd0 : grp3_reg;
        mdm   = clr ? 2'd0 : mod_reg;
        b     = req.code_byte;
        zsz   = (!rex_w && opsz) ? 4'd2 : 4'd4;

        phase_next = ph;
        opsz_next  = opsz;
        adsz_next  = adsz;
        rex_w_next = rex_w;
        esc_next   = esc;
        mrm_next   = clr ? 1'b0 : mrm_reg;
        imm_next   = imm;
        tail_next  = tail;
        grp3_next  = grp3;
        mod_next   = mdm;
        ends       = 1'b0;
        bad        = 1'b0;
        take_op    = 1'b0;
        cls        = '0;
        disp       = 4'd0;

        case (ph)
            xild_pkg::PH_ESC:
            begin
                if (b == xild_pkg::OP_0F38 || b == xild_pkg::OP_0F3A)
                begin
                    esc_next   = (b == xild_pkg::OP_0F38) ? xild_pkg::ESC_0F38
                                                          : xild_pkg::ESC_0F3A;
                    phase_next = xild_pkg::PH_ESC3;
                end
                else
                begin
                    cls = xild_pkg::class_two(b);
                    if (!cls.ok) bad = 1'b1;
                    else take_op = 1'b1;
                end
            end
            xild_pkg::PH_ESC3:
            begin
                cls = xild_pkg::mk(1'b1, (esc == xild_pkg::ESC_0F3A) ? xild_pkg::K1
                                                                      : xild_pkg::K0);
                take_op = 1'b1;
            end
            xild_pkg::PH_MODRM:
            begin
                if (grp3 != 2'd0 && b[5:3] <= 3'd1)
                    imm_next = (grp3 == 2'd1) ? 4'd1 : zsz;
                mod_next = b[7:6];
                if (b[7:6] != 2'd3 && b[2:0] == 3'd4)
                    phase_next = xild_pkg::PH_SIB;
                else
                begin
                    if (b[7:6] == 2'd0 && b[2:0] == 3'd5) disp = 4'd4;
                    else if (b[7:6] == 2'd1)              disp = 4'd1;
                    else if (b[7:6] == 2'd2)              disp = 4'd4;
                    tail_next  = disp + imm_next;
                    phase_next = xild_pkg::PH_TAIL;
                    ends       = (tail_next == 4'd0);
                end
            end
            xild_pkg::PH_SIB:
            begin
                if (mdm == 2'd0 && b[2:0] == 3'd5) disp = 4'd4;
                else if (mdm == 2'd1)              disp = 4'd1;
                else if (mdm == 2'd2)              disp = 4'd4;
                tail_next  = disp + imm;
                phase_next = xild_pkg::PH_TAIL;
                ends       = (tail_next == 4'd0);
            end
            xild_pkg::PH_TAIL:
            begin
                if (tail != 4'd0) tail_next = tail - 4'd1;
                ends = (tail_next == 4'd0);
            end
            default:
            begin
                if (b inside {8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26,
                              8'h64, 8'h65})
                    phase_next = xild_pkg::PH_PREFIX;
                else if (b == xild_pkg::OP_OPSZ) opsz_next = 1'b1;
                else if (b == xild_pkg::OP_ADSZ) adsz_next = 1'b1;
                else if (b inside {[8'h40:8'h4F]}) rex_w_next = b[3];
                else if (b == xild_pkg::OP_ESC)
                begin
                    esc_next   = xild_pkg::ESC_0F;
                    phase_next = xild_pkg::PH_ESC;
                end
                else
                begin
                    cls = xild_pkg::class_one(b);
                    if (!cls.ok) bad = 1'b1;
                    else
                    begin
                        grp3_next = (b == xild_pkg::OP_GRP3B) ? 2'd1 :
                                    (b == xild_pkg::OP_GRP3V) ? 2'd2 : 2'd0;
                        take_op = 1'b1;
                    end
                end
            end
        endcase

        if (take_op)
        begin
            mrm_next = cls.mrm;
            imm_next = imm_of(cls.kind, zsz, adsz, rex_w);
            if (cls.mrm)
                phase_next = xild_pkg::PH_MODRM;
            else
            begin
                tail_next  = imm_next;
                phase_next = xild_pkg::PH_TAIL;
                ends       = (imm_next == 4'd0);
            end
        end

        if (!bad && !ends && idx >= LAST_IDX) bad = 1'b1;

        res.end_of_instruction = !bad && ends;
        res.instr_length       = (!bad && ends) ? idx + 4'd1 : 4'd0;
        res.invalid            = bad;
        res.byte_index         = idx;
        bytes_seen_next        = idx + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= xild_pkg::PH_PREFIX;
            bytes_seen_reg <= '0;
            opsz_reg       <= 1'b0;
            adsz_reg       <= 1'b0;
            rex_w_reg      <= 1'b0;
            esc_reg        <= '0;
            mrm_reg        <= 1'b0;
            imm_reg        <= '0;
            tail_reg       <= '0;
            grp3_reg       <= '0;
            mod_reg        <= '0;
        end
        else if (step)
        begin
            if (bad || ends)
            begin
                phase_reg      <= xild_pkg::PH_PREFIX;
                bytes_seen_reg <= '0;
                opsz_reg       <= 1'b0;
                adsz_reg       <= 1'b0;
                rex_w_reg      <= 1'b0;
                esc_reg        <= '0;
                mrm_reg        <= 1'b0;
                imm_reg        <= '0;
                tail_reg       <= '0;
                grp3_reg       <= '0;
                mod_reg        <= '0;
            end
            else
            begin
                phase_reg      <= phase_next;
                bytes_seen_reg <= bytes_seen_next;
                opsz_reg       <= opsz_next;
                adsz_reg       <= adsz_next;
                rex_w_reg      <= rex_w_next;
                esc_reg        <= esc_next;
                mrm_reg        <= mrm_next;
                imm_reg        <= imm_next;
                tail_reg       <= tail_next;
                grp3_reg       <= grp3_next;
                mod_reg        <= mod_next;
            end
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_seen_reg <= LAST_IDX) else $error("byte index past limit");
    a_end_xor_bad: assert property (@(posedge clk) disable iff (!rst_n)
        !(res.end_of_instruction && res.invalid)) else $error("end and invalid");
    a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
        res.end_of_instruction |-> res.instr_length == res.byte_index + 4'd1)
        else $error("length mismatch");
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (bad || ends)) |=> bytes_seen_reg == 4'd0)
        else $error("index not cleared");

endmodule

### hdl/x86_64_instruction_length_decoder_top.sv
// The result of each accepted request byte is captured in the result register.
// Throughput: one byte per cycle; the result register and the per-byte
//   decode state advance together whenever the output slot is free or taken.
// Reset: rst_n clears the decode state to the prefix phase and empties the
//   result register.
// ----------------------------------------------------------------------------
// x86_64_instruction_length_decoder_top: streaming x86-64 length decoder
// Accepts one code byte per request and returns one result per byte that
// marks instruction ends, lengths and invalid encodings.
// ----------------------------------------------------------------------------
module x86_64_instruction_length_decoder_top #(
    parameter int MAX_LENGTH = 15
) (
    input logic          clk,
    input logic          rst_n,
    xild_stream_if.sink   in_ch,
    xild_stream_if.source out_ch
);

    xild_pkg::res_t res_comb;
    xild_pkg::res_t res_reg;
    logic           valid_reg;
    logic           step;

    // take a new byte whenever the result slot is empty or drains this cycle
    assign in_ch.ready = !valid_reg || out_ch.ready;
    assign step        = in_ch.valid && in_ch.ready;

    xild_core #(.MAX_LENGTH(MAX_LENGTH)) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (in_ch.data),
        .res   (res_comb)
    );

    // hold the result until the sink takes it; advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ch.ready)
            valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_comb;
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.data  = res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped while stalled");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_ch.valid) else $error("accepted byte lost");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !step) |=> !out_ch.valid)
        else $error("result repeated");

endmodule

### bench/x86_64_instruction_length_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_64_instruction_length_decoder_top_tb: length decoder bench
// Streams code bytes into the decoder, predicts every per-byte result with a
// local length model and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module x86_64_instruction_length_decoder_top_tb;

    localparam int MAXLEN = 15;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    xild_stream_if #(.T(xild_pkg::req_t)) in_ch ();
    xild_stream_if #(.T(xild_pkg::res_t)) out_ch ();

    x86_64_instruction_length_decoder_top #(.MAX_LENGTH(MAXLEN)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // Decoder state that the prediction keeps between bytes.
    xild_pkg::phase_t dec_phase;
    logic [3:0] dec_count;
    logic       dec_opsz;
    logic       dec_adsz;
    logic       dec_rexw;
    logic [1:0] dec_esc;
    logic [3:0] dec_imm;
    logic [3:0] dec_tail;
    logic [1:0] dec_grp3;
    logic [1:0] dec_mod;

    xild_pkg::res_t expected_results[$];
    int   fail_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_idle_pct;

    // Free-running clock; 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [3:0] z_bytes();
        return (!dec_rexw && dec_opsz) ? 4'd2 : 4'd4;
    endfunction

    function automatic logic [3:0] imm_len(input logic [3:0] kind);
        case (kind)
            xild_pkg::K1:     return 4'd1;
            xild_pkg::K2:     return 4'd2;
            xild_pkg::K3:     return 4'd3;
            xild_pkg::K4:     return 4'd4;
            xild_pkg::KZ:     return z_bytes();
            xild_pkg::KFAR:   return z_bytes() + 4'd2;
            xild_pkg::KMOFFS: return dec_adsz ? 4'd4 : 4'd8;
            xild_pkg::KMOV:   return dec_rexw ? 4'd8 : z_bytes();
            default:          return 4'd0;
        endcase
    endfunction

    // Opcode tables, kept apart from the package so a table slip shows up.
    function automatic xild_pkg::cls_t opc(input logic m, input logic [3:0] k);
        xild_pkg::cls_t c;
        c.ok = 1'b1;
        c.mrm = m;
        c.kind = k;
        return c;
    endfunction

    function automatic xild_pkg::cls_t lookup_one(input logic [7:0] op);
        int v;
        v = int'(op);
        if (v < 'h40)
        begin
            if (v % 8 <= 3) return opc(1'b1, xild_pkg::K0);
            if (v % 8 == 4) return opc(1'b0, xild_pkg::K1);
            if (v % 8 == 5) return opc(1'b0, xild_pkg::KZ);
            if (v == 'h06 || v == 'h07 || v == 'h0E || v == 'h16 || v == 'h17
                || v == 'h1E || v == 'h1F) return opc(1'b0, xild_pkg::K0);
            return '0;
        end
        if (v < 'h60) return opc(1'b0, xild_pkg::K0);
        if (v >= 'h70 && v <= 'h7F) return opc(1'b0, xild_pkg::K1);
        if (v >= 'h84 && v <= 'h8F) return opc(1'b1, xild_pkg::K0);
        if ((v >= 'h90 && v <= 'h99) || (v >= 'h9C && v <= 'h9F))
            return opc(1'b0, xild_pkg::K0);
        if (v >= 'hA0 && v <= 'hA3) return opc(1'b0, xild_pkg::KMOFFS);
        if ((v >= 'hA4 && v <= 'hA7) || (v >= 'hAA && v <= 'hAF))
            return opc(1'b0, xild_pkg::K0);
        if (v >= 'hB0 && v <= 'hB7) return opc(1'b0, xild_pkg::K1);
        if (v >= 'hB8 && v <= 'hBF) return opc(1'b0, xild_pkg::KMOV);
        if ((v >= 'hD8 && v <= 'hDF) || (v >= 'hD0 && v <= 'hD3))
            return opc(1'b1, xild_pkg::K0);
        if (v >= 'hE0 && v <= 'hE7) return opc(1'b0, xild_pkg::K1);
        if ((v >= 'hEC && v <= 'hEF) || (v >= 'hF8 && v <= 'hFD))
            return opc(1'b0, xild_pkg::K0);
        case (v)
            'h68: return opc(1'b0, xild_pkg::KZ);
            'h69: return opc(1'b1, xild_pkg::KZ);
            'h6A: return opc(1'b0, xild_pkg::K1);
            'h6B, 'h80, 'h82, 'h83, 'hC0, 'hC1, 'hC6: return opc(1'b1, xild_pkg::K1);
            'h81, 'hC7: return opc(1'b1, xild_pkg::KZ);
            'h9A, 'hEA: return opc(1'b0, xild_pkg::KFAR);
            'hA8, 'hCD, 'hD4, 'hD5, 'hEB: return opc(1'b0, xild_pkg::K1);
            'hA9: return opc(1'b0, xild_pkg::KZ);
            'hC2, 'hCA: return opc(1'b0, xild_pkg::K2);
            'hC3, 'hC9, 'hCB, 'hCC, 'hCE, 'hCF, 'hD7, 'hF4, 'hF5:
                return opc(1'b0, xild_pkg::K0);
            'hC4, 'hC5, 'hF6, 'hF7, 'hFE, 'hFF: return opc(1'b1, xild_pkg::K0);
            'hC8: return opc(1'b0, xild_pkg::K3);
            'hE8, 'hE9: return opc(1'b0, xild_pkg::K4);
            default: return '0;
        endcase
    endfunction

    function automatic xild_pkg::cls_t lookup_two(input logic [7:0] op);
        int v;
        v = int'(op);
        if (v >= 'h80 && v <= 'h8F) return opc(1'b0, xild_pkg::K4);
        if ((v >= 'h90 && v <= 'h9F) || (v >= 'h40 && v <= 'h4F))
            return opc(1'b1, xild_pkg::K0);
        if (v >= 'hC8 && v <= 'hCF) return opc(1'b0, xild_pkg::K0);
        if (v >= 'h20 && v <= 'h23) return opc(1'b1, xild_pkg::K0);
        if (v >= 'h30 && v <= 'h33) return opc(1'b0, xild_pkg::K0);
        case (v)
            'hA4, 'hAC, 'hBA: return opc(1'b1, xild_pkg::K1);
            'hA3, 'hAB, 'hB3, 'hBB, 'hA5, 'hAD, 'hAF, 'hB6, 'hB7, 'hBE, 'hBF,
            'hBC, 'hBD, 'hB2, 'hB4, 'hB5, 'h1F, 'hC0, 'hC1, 'hB0, 'hB1, 'hC7:
                return opc(1'b1, xild_pkg::K0);
            'hA0, 'hA1, 'hA8, 'hA9, 'h05, 'h07, 'h34, 'h35:
                return opc(1'b0, xild_pkg::K0);
            default: return '0;
        endcase
    endfunction

    function automatic void clear_decode();
        dec_phase = xild_pkg::PH_PREFIX;
        dec_count = '0;
        dec_opsz = 1'b0;
        dec_adsz = 1'b0;
        dec_rexw = 1'b0;
        dec_esc = xild_pkg::ESC_NONE;
        dec_imm = '0;
        dec_tail = '0;
        dec_grp3 = '0;
        dec_mod = '0;
    endfunction

    // Opcode resolved: go to ModRM or to the trailing bytes.
    function automatic logic opcode_done(input xild_pkg::cls_t c);
        dec_imm = imm_len(c.kind);
        if (c.mrm)
        begin
            dec_phase = xild_pkg::PH_MODRM;
            return 1'b0;
        end
        dec_tail = dec_imm;
        dec_phase = xild_pkg::PH_TAIL;
        return dec_tail == 4'd0;
    endfunction

    function automatic logic disp_done(input logic [3:0] disp);
        dec_tail = disp + dec_imm;
        dec_phase = xild_pkg::PH_TAIL;
        return dec_tail == 4'd0;
    endfunction

    // Predict the result of one code byte and advance the decode state.
    function automatic xild_pkg::res_t decode_byte(input xild_pkg::req_t r);
        xild_pkg::res_t res;
        logic [3:0] pos;
        logic [3:0] disp;
        logic       ends;
        logic       bad;
        xild_pkg::cls_t c;
        logic [7:0] b;
        b = r.code_byte;
        ends = 1'b0;
        bad = 1'b0;
        disp = '0;
        if (r.restart) clear_decode();
        pos = dec_count;
        case (dec_phase)
            xild_pkg::PH_ESC:
            begin
                if (b == xild_pkg::OP_0F38 || b == xild_pkg::OP_0F3A)
                begin
                    dec_esc = (b == xild_pkg::OP_0F38) ? xild_pkg::ESC_0F38
                                                       : xild_pkg::ESC_0F3A;
                    dec_phase = xild_pkg::PH_ESC3;
                end
                else
                begin
                    c = lookup_two(b);
                    if (!c.ok) bad = 1'b1;
                    else ends = opcode_done(c);
                end
            end
            xild_pkg::PH_ESC3:
                ends = opcode_done(opc(1'b1, (dec_esc == xild_pkg::ESC_0F3A) ?
                                             xild_pkg::K1 : xild_pkg::K0));
            xild_pkg::PH_MODRM:
            begin
                if (dec_grp3 != 2'd0 && b[5:3] <= 3'd1)
                    dec_imm = (dec_grp3 == 2'd1) ? 4'd1 : z_bytes();
                dec_mod = b[7:6];
                if (b[7:6] != 2'd3 && b[2:0] == 3'd4) dec_phase = xild_pkg::PH_SIB;
                else
                begin
                    if (b[7:6] == 2'd0 && b[2:0] == 3'd5) disp = 4'd4;
                    else if (b[7:6] == 2'd1) disp = 4'd1;
                    else if (b[7:6] == 2'd2) disp = 4'd4;
                    ends = disp_done(disp);
                end
            end
            xild_pkg::PH_SIB:
            begin
                if (dec_mod == 2'd0 && b[2:0] == 3'd5) disp = 4'd4;
                else if (dec_mod == 2'd1) disp = 4'd1;
                else if (dec_mod == 2'd2) disp = 4'd4;
                ends = disp_done(disp);
            end
            xild_pkg::PH_TAIL:
            begin
                if (dec_tail > 4'd0) dec_tail = dec_tail - 4'd1;
                ends = dec_tail == 4'd0;
            end
            default:
            begin
                if (b inside {8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26,
                              8'h64, 8'h65})
                    ;
                else if (b == xild_pkg::OP_OPSZ) dec_opsz = 1'b1;
                else if (b == xild_pkg::OP_ADSZ) dec_adsz = 1'b1;
                else if (b[7:4] == 4'h4) dec_rexw = b[3];
                else if (b == xild_pkg::OP_ESC)
                begin
                    dec_esc = xild_pkg::ESC_0F;
                    dec_phase = xild_pkg::PH_ESC;
                end
                else
                begin
                    c = lookup_one(b);
                    if (!c.ok) bad = 1'b1;
                    else
                    begin
                        dec_grp3 = (b == xild_pkg::OP_GRP3B) ? 2'd1 :
                                   (b == xild_pkg::OP_GRP3V) ? 2'd2 : 2'd0;
                        ends = opcode_done(c);
                    end
                end
            end
        endcase
        if (!bad && !ends && int'(pos) + 1 >= MAXLEN) bad = 1'b1;
        res.end_of_instruction = !bad && ends;
        res.instr_length = (!bad && ends) ? pos + 4'd1 : 4'd0;
        res.invalid = bad;
        res.byte_index = pos;
        if (bad || ends) clear_decode();
        else dec_count = pos + 4'd1;
        return res;
    endfunction

    // Send one code byte; predict its result when it is accepted. Valid stays
    // high after the accept so the next byte can follow at once.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        xild_pkg::req_t r;
        r.code_byte = b;
        r.restart = rs;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= r;
        do @(posedge clk); while (!in_ch.ready);
        expected_results.push_back(decode_byte(r));
    endtask

    task automatic send_seq(input logic [7:0] s[$]);
        foreach (s[i]) send_byte(s[i], 1'b0);
    endtask

    // Drop valid and hold the sender until every predicted result has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Receiver: random stalls; compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        xild_pkg::res_t e;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result %p", out_ch.data);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_ch.data.end_of_instruction !== e.end_of_instruction)
                    begin
                        $error("end_of_instruction exp %0d got %0d",
                               e.end_of_instruction, out_ch.data.end_of_instruction);
                        fail_count++;
                    end
                    if (out_ch.data.instr_length !== e.instr_length)
                    begin
                        $error("instr_length exp %0d got %0d",
                               e.instr_length, out_ch.data.instr_length);
                        fail_count++;
                    end
                    if (out_ch.data.invalid !== e.invalid)
                    begin
                        $error("invalid exp %0d got %0d", e.invalid, out_ch.data.invalid);
                        fail_count++;
                    end
                    if (out_ch.data.byte_index !== e.byte_index)
                    begin
                        $error("byte_index exp %0d got %0d",
                               e.byte_index, out_ch.data.byte_index);
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Directed: prefixes, escapes, group 3, SIB/disp forms, moffs, far, BT.
    task automatic test_directed();
        send_seq('{8'h90});
        send_seq('{8'h66, 8'h67, 8'hF0, 8'h48, 8'hB8, 8'h01, 8'h02, 8'h03, 8'h04,
                   8'h05, 8'h06, 8'h07, 8'h08});
        send_seq('{8'h67, 8'hA1, 8'h01, 8'h02, 8'h03, 8'h04});
        send_seq('{8'hA0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08});
        send_seq('{8'h66, 8'h9A, 8'h01, 8'h02, 8'h03, 8'h04});
        send_seq('{8'hF6, 8'h00, 8'h55});
        send_seq('{8'h66, 8'hF7, 8'hC8, 8'h01, 8'h02});
        send_seq('{8'hF7, 8'h10});
        send_seq('{8'h8B, 8'h04, 8'h25, 8'h01, 8'h02, 8'h03, 8'h04});
        send_seq('{8'h8B, 8'h44, 8'h24, 8'h08});
        send_seq('{8'h81, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                   8'h08});
        send_seq('{8'h0F, 8'hA3, 8'hC0});
        send_seq('{8'h0F, 8'h3A, 8'h0F, 8'hC1, 8'h08});
        send_seq('{8'h0F, 8'h38, 8'h00, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04});
        send_seq('{8'h0F, 8'h84, 8'h01, 8'h02, 8'h03, 8'h04});
        send_seq('{8'h0F, 8'hFF});
        send_seq('{8'h06, 8'h62, 8'hFF, 8'h00, 8'hC8, 8'h01, 8'h02, 8'h03});
        // Fifteen prefixes: too long on the last one.
        for (int i = 0; i < 15; i++) send_byte(8'h2E, 1'b0);
        // Restart mid-instruction drops the partial one.
        send_seq('{8'hE8, 8'h01});
        send_byte(8'hC3, 1'b1);
        send_seq('{8'h66, 8'h48, 8'h68, 8'h01, 8'h02, 8'h03, 8'h04});
        send_seq('{8'h44, 8'h67, 8'hEA, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06});
    endtask

    // Random: mostly well-formed instructions, some noise and restarts.
    task automatic test_random(input int n);
        int sent;
        int k;
        logic [7:0] op;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
                sent++;
            end
            else
            begin
                k = $urandom_range(3);
                repeat (k)
                begin
                    case ($urandom_range(3))
                        0: send_byte(xild_pkg::OP_OPSZ, 1'b0);
                        1: send_byte(xild_pkg::OP_ADSZ, 1'b0);
                        2: send_byte(8'h40 | 8'($urandom_range(15)), 1'b0);
                        default: send_byte(8'hF3, 1'b0);
                    endcase
                    sent++;
                end
                case ($urandom_range(3))
                    0:
                    begin
                        send_byte(xild_pkg::OP_ESC, 1'b0);
                        sent++;
                        do op = 8'($urandom_range(255)); while (!lookup_two(op).ok
                            && op != xild_pkg::OP_0F38 && op != xild_pkg::OP_0F3A);
                    end
                    default:
                        do op = 8'($urandom_range(255));
                        while (!lookup_one(op).ok || op == xild_pkg::OP_ESC
                               || op == xild_pkg::OP_OPSZ || op == xild_pkg::OP_ADSZ
                               || op[7:4] == 4'h4);
                endcase
                send_byte(op, 1'b0);
                sent++;
                // Fill modrm/sib/immediates with random bytes until the end.
                while (dec_phase != xild_pkg::PH_PREFIX || dec_count != 4'd0)
                begin
                    send_byte(8'($urandom_range(255)), 1'b0);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycle_count = 0;
        fail_count = 0;
        send_idle_pct = 18;
        recv_idle_pct = 57;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        clear_decode();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400);
        drain();
        send_idle_pct = 57;
        recv_idle_pct = 18;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(400);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
